// ----- rtl/ltbq_pkg.sv -----
// package: shared constants and item types of the log time-bucket queue index core
`timescale 1ns / 1ps
`default_nettype none

package ltbq_pkg;

    // default geometry
    localparam int BUCKETS_PER_GROUP = 8;
    localparam int BUCKET_GROUPS     = 4;
    localparam int TIME_WIDTH        = 32;

    // fixed field widths
    localparam int ID_W = 5;
    localparam int TS_W = 32;

    // operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [TS_W-1:0] time_slice;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] bucket_index;
        logic            out_of_range;
        logic [ID_W-1:0] physical_bucket;
        logic            shifted;
        logic [ID_W-1:0] recycled_bucket;
        logic [ID_W-1:0] merge_into_bucket;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/ltbq_lookup.sv -----
// time slice to logical bucket position, one combinational pass
`timescale 1ns / 1ps
`default_nettype none

module ltbq_lookup #(
    parameter int BUCKETS_PER_GROUP = ltbq_pkg::BUCKETS_PER_GROUP,
    parameter int BUCKET_GROUPS     = ltbq_pkg::BUCKET_GROUPS,
    parameter int TIME_WIDTH        = ltbq_pkg::TIME_WIDTH
) (
    input  wire logic [TIME_WIDTH-1:0] i_ts,
    input  wire logic [TIME_WIDTH-1:0] i_base,
    output logic      [$clog2(BUCKETS_PER_GROUP*BUCKET_GROUPS > 1 ?
                              BUCKETS_PER_GROUP*BUCKET_GROUPS : 2)-1:0] o_idx,
    output logic                       o_out_of_range
);

    localparam int NUM = BUCKETS_PER_GROUP * BUCKET_GROUPS;
    localparam int NW  = $clog2(NUM > 1 ? NUM : 2);
    localparam int LIM = ((1 << BUCKET_GROUPS) - 1) * BUCKETS_PER_GROUP;
    localparam int LW  = $clog2(LIM + 1);

    logic [TIME_WIDTH-1:0] delta;
    logic [LW-1:0]         d_low;
    logic                  at_or_before;
    logic [NW-1:0]         idx;

    assign delta        = i_ts - i_base;
    assign d_low        = delta[LW-1:0];
    assign at_or_before = (i_ts <= i_base);

    // delta at or above the span of all groups
    assign o_out_of_range = !at_or_before && (delta >= TIME_WIDTH'(LIM));

    // group g covers delta in [(2^g-1)*B, (2^(g+1)-1)*B), one compare pair per group
    always_comb begin
        logic [LW-1:0] lo;
        logic [LW-1:0] hi;
        logic [LW-1:0] off;
        idx = '0;
        lo  = '0;
        hi  = '0;
        off = '0;
        for (int g = 0; g < BUCKET_GROUPS; g++) begin
            lo = LW'(((1 << g) - 1) * BUCKETS_PER_GROUP);
            hi = LW'(((2 << g) - 1) * BUCKETS_PER_GROUP);
            if (d_low >= lo && d_low < hi) begin
                off = (d_low - lo) >> g;
                idx = idx | (NW'(g * BUCKETS_PER_GROUP) + NW'(off));
            end
        end
    end

    assign o_idx = (at_or_before || o_out_of_range) ? '0 : idx;

endmodule

`default_nettype wire

// ----- rtl/ltbq_map.sv -----
// position map registers with read port and group-wise shift
`timescale 1ns / 1ps
`default_nettype none

module ltbq_map #(
    parameter int BUCKETS_PER_GROUP = ltbq_pkg::BUCKETS_PER_GROUP,
    parameter int BUCKET_GROUPS     = ltbq_pkg::BUCKET_GROUPS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_shift,
    input  wire logic [BUCKET_GROUPS-1:0]     i_next_low,
    input  wire logic [$clog2(BUCKETS_PER_GROUP*BUCKET_GROUPS > 1 ?
                              BUCKETS_PER_GROUP*BUCKET_GROUPS : 2)-1:0] i_rd_idx,
    output logic      [ltbq_pkg::ID_W-1:0]    o_rd_id,
    output logic      [ltbq_pkg::ID_W-1:0]    o_head_id,
    output logic      [ltbq_pkg::ID_W-1:0]    o_second_id
);

    localparam int NUM    = BUCKETS_PER_GROUP * BUCKET_GROUPS;
    localparam int SECOND = (NUM > 1) ? 1 : 0;

    logic [ltbq_pkg::ID_W-1:0] r_map [NUM];
    logic [ltbq_pkg::ID_W-1:0] n_map [NUM];
    logic [BUCKET_GROUPS-1:0]  grp_en;

    // group g shifts when the new base is a multiple of 2^g
    always_comb begin
        grp_en[0] = 1'b1;
        for (int g = 1; g < BUCKET_GROUPS; g++) begin
            grp_en[g] = grp_en[g-1] & ~i_next_low[g-1];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM; i++) begin
            n_map[i] = r_map[i];
            if (i_shift && grp_en[i / BUCKETS_PER_GROUP]) begin
                // top of the last shifting group takes the recycled id
                if ((i % BUCKETS_PER_GROUP == BUCKETS_PER_GROUP - 1) &&
                    ((i / BUCKETS_PER_GROUP == BUCKET_GROUPS - 1) ||
                     i_next_low[i / BUCKETS_PER_GROUP])) begin
                    n_map[i] = r_map[0];
                end else begin
                    n_map[i] = r_map[(i + 1 < NUM) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM; i++) begin
            if (!i_rst_n) begin
                r_map[i] <= ltbq_pkg::ID_W'(i);
            end else begin
                r_map[i] <= n_map[i];
            end
        end
    end

    assign o_rd_id     = r_map[i_rd_idx];
    assign o_head_id   = r_map[0];
    assign o_second_id = r_map[SECOND];

endmodule

`default_nettype wire

// ----- rtl/log_time_bucket_queue_index_core.sv -----
// top level of the log time-bucket queue index core
`timescale 1ns / 1ps
`default_nettype none

// Index core of a logarithmic time-bucket queue. Logical buckets form
// BUCKET_GROUPS groups of BUCKETS_PER_GROUP buckets; buckets of group g are
// 2^g time slices wide and start just after the base time slice. A lookup
// item returns the logical position of a time slice and the physical bucket
// id mapped there; a tick item advances the base by one slice when due and
// rotates the position map, reporting the recycled and merge-target ids.
// Rate: one item per clock, busy never rises, so start may be held high.
// Each item is held in the input register, passes once through the lookup
// and map logic and is then caught in the result register, which drives
// o_valid. The state update lands with the result register, so the next item
// already sees it. Results must be taken in the cycle o_valid is high: there
// is no back-pressure on the result side.
module log_time_bucket_queue_index_core #(
    parameter int BUCKETS_PER_GROUP = ltbq_pkg::BUCKETS_PER_GROUP,
    parameter int BUCKET_GROUPS     = ltbq_pkg::BUCKET_GROUPS,
    parameter int TIME_WIDTH        = ltbq_pkg::TIME_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ltbq_pkg::t_in_item i_item,
    output logic                    o_valid,
    output ltbq_pkg::t_out_item     o_result
);

    localparam int NUM = BUCKETS_PER_GROUP * BUCKETS_PER_GROUP / BUCKETS_PER_GROUP
                         * BUCKET_GROUPS;
    localparam int NW  = $clog2(NUM > 1 ? NUM : 2);
    localparam int CW  = (TIME_WIDTH < ltbq_pkg::TS_W) ? TIME_WIDTH : ltbq_pkg::TS_W;

    // input register
    logic                r_in_vld;
    ltbq_pkg::t_in_item  r_in;

    // state and result register
    logic [TIME_WIDTH-1:0] r_base;
    logic [TIME_WIDTH-1:0] n_base;
    logic                  r_out_vld;
    ltbq_pkg::t_out_item   r_out;
    ltbq_pkg::t_out_item   n_out;

    logic [TIME_WIDTH-1:0]     ts;
    logic [TIME_WIDTH-1:0]     next_base;
    logic                      is_tick;
    logic                      tick_due;
    logic [NW-1:0]             lk_idx;
    logic                      lk_oor;
    logic [ltbq_pkg::ID_W-1:0] rd_id;
    logic [ltbq_pkg::ID_W-1:0] head_id;
    logic [ltbq_pkg::ID_W-1:0] second_id;

    // nothing ever holds the input off
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    // time is taken modulo 2^TIME_WIDTH
    assign ts        = TIME_WIDTH'(r_in.time_slice[CW-1:0]);
    assign next_base = r_base + 1'b1;
    assign is_tick   = (r_in.operation == ltbq_pkg::OP_TICK);

    // a base of all ones never advances
    assign tick_due = r_in_vld && is_tick && (r_base != '1) && (next_base <= ts);

    ltbq_lookup #(
        .BUCKETS_PER_GROUP (BUCKETS_PER_GROUP),
        .BUCKET_GROUPS     (BUCKET_GROUPS),
        .TIME_WIDTH        (TIME_WIDTH)
    ) u_lookup (
        .i_ts           (ts),
        .i_base         (r_base),
        .o_idx          (lk_idx),
        .o_out_of_range (lk_oor)
    );

    ltbq_map #(
        .BUCKETS_PER_GROUP (BUCKETS_PER_GROUP),
        .BUCKET_GROUPS     (BUCKET_GROUPS)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (tick_due),
        .i_next_low  (next_base[BUCKET_GROUPS-1:0]),
        .i_rd_idx    (lk_idx),
        .o_rd_id     (rd_id),
        .o_head_id   (head_id),
        .o_second_id (second_id)
    );

    // result assembly: unused fields of each operation stay zero
    always_comb begin
        n_out  = '0;
        n_base = r_base;
        if (is_tick) begin
            if (tick_due) begin
                n_base                  = next_base;
                n_out.shifted           = 1'b1;
                n_out.recycled_bucket   = head_id;
                n_out.merge_into_bucket = second_id;
            end
        end else if (!lk_oor) begin
            n_out.bucket_index    = ltbq_pkg::ID_W'(lk_idx);
            n_out.physical_bucket = rd_id;
        end else begin
            n_out.out_of_range = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_base    <= '0;
        end else begin
            r_out_vld <= r_in_vld;
            r_base    <= n_base;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // every registered item yields its result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_valid)
        else $error("item in input register produced no result");

    // the base only ever steps by one slice
    a_base_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_base)) |-> (r_base == $past(r_base) + 1'b1))
        else $error("base time moved by other than one slice");

    // a shift is only reported for a tick item
    a_shift_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.shifted) |-> ($past(r_in.operation) == ltbq_pkg::OP_TICK))
        else $error("shift reported for a lookup item");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench of the log time-bucket queue index core: random and directed lookups and ticks
`timescale 1ns / 1ps

module tb_top;
    import ltbq_pkg::*;

    localparam int NUM_BUCKETS = BUCKETS_PER_GROUP * BUCKET_GROUPS;
    localparam logic [63:0] TIME_MASK = {64{1'b1}} >> (64 - TIME_WIDTH);
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT = 100000;
    localparam int TAIL_CYCLES = 8;

    // one item waiting to be offered, with an optional drain-first marker
    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  i_item = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    log_time_bucket_queue_index_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #6 i_clk = ~i_clk;

    // items still to be sent, and results owed by the core in arrival order
    t_pending  lookups_and_ticks[$];
    t_out_item bucket_results_due[$];

    // shadow copy of the core state, advanced once per accepted item
    logic [TIME_WIDTH-1:0] base_slice;
    logic [ID_W-1:0]       slot_map[NUM_BUCKETS];

    // base time as the stimulus generator sees it, to aim times near the window
    logic [TIME_WIDTH-1:0] gen_base;

    int unsigned mismatches = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_lookups = 0;
    int unsigned n_ticks = 0;
    int unsigned n_shifts = 0;
    int unsigned n_out_of_range = 0;
    int unsigned n_drains = 0;
    int unsigned cycles = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, n_checked, msg);
        mismatches++;
    endtask

    // works out the result of one item and moves the shadow state on
    function automatic t_out_item step_bucket_index(input t_in_item it);
        t_out_item       r;
        logic [63:0]     ts;
        logic [63:0]     delta;
        logic [63:0]     q;
        logic [63:0]     span;
        logic [63:0]     idx;
        logic [63:0]     next;
        logic [ID_W-1:0] spare;
        int              g;
        int              k;
        int              top;
        bit              stop;
        r = '0;
        ts = 64'(it.time_slice) & TIME_MASK;
        if (it.operation == OP_LOOKUP) begin
            if (ts <= 64'(base_slice)) begin
                // past or present time lands in the first bucket
                r.physical_bucket = slot_map[0];
            end else begin
                delta = ts - 64'(base_slice);
                q = delta / 64'(BUCKETS_PER_GROUP);
                if (q >= (64'd1 << BUCKET_GROUPS) - 64'd1) begin
                    r.out_of_range = 1'b1;
                end else begin
                    // group number is floor(log2(q + 1))
                    g = 0;
                    span = q + 64'd1;
                    while (span > 64'd1) begin
                        span = span >> 1;
                        g++;
                    end
                    idx = 64'(g) * 64'(BUCKETS_PER_GROUP)
                        + ((delta - ((64'd1 << g) - 64'd1) * 64'(BUCKETS_PER_GROUP)) >> g);
                    if (idx >= 64'(NUM_BUCKETS)) begin
                        r.out_of_range = 1'b1;
                    end else begin
                        r.bucket_index = idx[ID_W-1:0];
                        r.physical_bucket = slot_map[idx];
                    end
                end
            end
        end else if (64'(base_slice) != TIME_MASK) begin
            next = 64'(base_slice) + 64'd1;
            if (next <= ts) begin
                base_slice = next[TIME_WIDTH-1:0];
                spare = slot_map[0];
                r.shifted = 1'b1;
                r.recycled_bucket = spare;
                r.merge_into_bucket = (NUM_BUCKETS > 1) ?
                    slot_map[NUM_BUCKETS > 1 ? 1 : 0] : spare;
                // group 0 always rotates; higher groups follow while the new base is aligned
                stop = 1'b0;
                for (g = 0; g < BUCKET_GROUPS && !stop; g++) begin
                    for (k = 0; k < BUCKETS_PER_GROUP; k++) begin
                        if (g * BUCKETS_PER_GROUP + k + 1 < NUM_BUCKETS)
                            slot_map[g * BUCKETS_PER_GROUP + k] =
                                slot_map[g * BUCKETS_PER_GROUP + k + 1];
                    end
                    top = (g + 1) * BUCKETS_PER_GROUP - 1;
                    if (g + 1 == BUCKET_GROUPS
                        || (next & ((64'd1 << (g + 1)) - 64'd1)) != 64'd0) begin
                        slot_map[top] = spare;
                        stop = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // queues one item and tracks where the base will be once it is done
    task automatic queue_item(input logic op, input logic [31:0] ts, input bit drain_first);
        t_pending p;
        p.item.operation = op;
        p.item.time_slice = ts;
        p.drain_first = drain_first;
        lookups_and_ticks.push_back(p);
        if (op == OP_TICK && 64'(gen_base) != TIME_MASK
            && 64'(gen_base) + 64'd1 <= (64'(ts) & TIME_MASK))
            gen_base = gen_base + 1'b1;
    endtask

    // driver: offers the head of the pending queue, with random gaps
    always @(posedge i_clk) begin
        t_out_item due;
        bit        idle;
        bit        calm;
        if (i_rst_n) begin
            if (start && !busy) begin
                due = step_bucket_index(i_item);
                bucket_results_due.push_back(due);
                void'(lookups_and_ticks.pop_front());
                n_sent++;
                if (i_item.operation == OP_LOOKUP) n_lookups++;
                else n_ticks++;
                if (due.shifted) n_shifts++;
                if (due.out_of_range) n_out_of_range++;
            end
            // a long stretch in the middle runs back to back
            calm = (n_sent >= 700 && n_sent < 1150);
            idle = !calm && ($urandom_range(0, 99) < 10);
            if (lookups_and_ticks.size() == 0 || idle) begin
                start <= 1'b0;
            end else if (lookups_and_ticks[0].drain_first && bucket_results_due.size() != 0) begin
                // hold off until every outstanding result is back
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_item <= lookups_and_ticks[0].item;
            end
        end
    end

    // monitor: every strobe must match the oldest outstanding result
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (bucket_results_due.size() == 0) begin
                report_mismatch("result strobe with no item outstanding");
            end else begin
                want = bucket_results_due.pop_front();
                if (o_result.bucket_index !== want.bucket_index)
                    report_mismatch($sformatf("bucket_index got %0d want %0d",
                        o_result.bucket_index, want.bucket_index));
                if (o_result.out_of_range !== want.out_of_range)
                    report_mismatch($sformatf("out_of_range got %0b want %0b",
                        o_result.out_of_range, want.out_of_range));
                if (o_result.physical_bucket !== want.physical_bucket)
                    report_mismatch($sformatf("physical_bucket got %0d want %0d",
                        o_result.physical_bucket, want.physical_bucket));
                if (o_result.shifted !== want.shifted)
                    report_mismatch($sformatf("shifted got %0b want %0b",
                        o_result.shifted, want.shifted));
                if (o_result.recycled_bucket !== want.recycled_bucket)
                    report_mismatch($sformatf("recycled_bucket got %0d want %0d",
                        o_result.recycled_bucket, want.recycled_bucket));
                if (o_result.merge_into_bucket !== want.merge_into_bucket)
                    report_mismatch($sformatf("merge_into_bucket got %0d want %0d",
                        o_result.merge_into_bucket, want.merge_into_bucket));
                n_checked++;
            end
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycles, bucket_results_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int          n;
        int unsigned pick;
        int unsigned sub;
        logic [31:0] ts;
        bit          drain;

        base_slice = '0;
        for (n = 0; n < NUM_BUCKETS; n++) slot_map[n] = ID_W'(n);
        gen_base = '0;

        // directed: window edges at base zero
        queue_item(OP_LOOKUP, 32'd0, 1'b0);          // present time
        queue_item(OP_LOOKUP, 32'd1, 1'b0);
        queue_item(OP_LOOKUP, 32'd7, 1'b0);          // last of group 0
        queue_item(OP_LOOKUP, 32'd9, 1'b0);          // first of group 1
        queue_item(OP_LOOKUP, 32'd119, 1'b0);        // last bucket
        queue_item(OP_LOOKUP, 32'd120, 1'b0);        // just beyond the last bucket
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_TICK, 32'd0, 1'b0);            // tick not due
        queue_item(OP_TICK, 32'd1, 1'b0);            // first shift, group 0 only
        queue_item(OP_LOOKUP, 32'd0, 1'b0);          // past time
        queue_item(OP_LOOKUP, 32'd1, 1'b0);
        // run the base up to 8 so that every group, the last included, rotates
        for (n = 0; n < 7; n++) queue_item(OP_TICK, 32'hFFFF_FFFF, n == 0);
        queue_item(OP_LOOKUP, 32'd127, 1'b0);
        queue_item(OP_LOOKUP, 32'd128, 1'b0);
        queue_item(OP_TICK, 32'd8, 1'b0);            // time equal to base
        queue_item(OP_LOOKUP, 32'hAAAA_AAAA, 1'b0);
        queue_item(OP_LOOKUP, 32'h5555_5555, 1'b0);
        queue_item(OP_TICK, 32'h0000_0007, 1'b0);    // time behind base

        // random: times mostly aimed around the live window
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            sub = $urandom_range(0, 9);
            drain = (n % 400 == 199);
            if (pick < 35) begin
                case (sub)
                    0: ts = $urandom;
                    1: ts = gen_base - $urandom_range(0, (gen_base > 20) ? 20 : gen_base);
                    2: ts = gen_base;
                    default: ts = gen_base + $urandom_range(1, 4);
                endcase
                queue_item(OP_TICK, ts, drain);
            end else begin
                case (sub)
                    0: ts = $urandom;
                    1: ts = gen_base - $urandom_range(0, (gen_base > 20) ? 20 : gen_base);
                    default: ts = gen_base + $urandom_range(0, 130);
                endcase
                queue_item(OP_LOOKUP, ts, drain);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (lookups_and_ticks.size() != 0 || bucket_results_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d items: %0d lookups (%0d out of range), %0d ticks (%0d shifts)",
            n_sent, n_lookups, n_out_of_range, n_ticks, n_shifts);
        $display("checked %0d results, final base slice %0d, %0d mismatching fields",
            n_checked, base_slice, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
